FILE: sv/bslh_pkg.sv
// Package with the types, constants and mixing functions shared by the lookup2 hash core.
package bslh_pkg;

    localparam logic [31:0] GOLDEN    = 32'h9e37_79b9;
    localparam int          GROUP_LEN = 12;
    localparam int          MIX_STEPS = 9;

    typedef logic [3:0] t_step;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } t_words;

    typedef struct packed {
        logic        first;
        logic [31:0] seed;
        logic        has_group;
        t_words      grp;
        logic        has_final;
        t_words      fin;
    } t_job;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_MIX
    } t_back_state;

    function automatic logic [4:0] mix_shift(t_step step);
        logic [4:0] sh;
        unique case (step)
            4'd0:    sh = 5'd13;
            4'd1:    sh = 5'd8;
            4'd2:    sh = 5'd13;
            4'd3:    sh = 5'd12;
            4'd4:    sh = 5'd16;
            4'd5:    sh = 5'd5;
            4'd6:    sh = 5'd3;
            4'd7:    sh = 5'd10;
            4'd8:    sh = 5'd15;
            default: sh = 5'd0;
        endcase
        return sh;
    endfunction

    function automatic t_words mix_step(t_words w, t_step step);
        t_words     r;
        logic [4:0] sh;
        r  = w;
        sh = mix_shift(step);
        unique case (step) inside
            4'd0, 4'd3, 4'd6: r.a = (w.a - w.b - w.c) ^ (w.c >> sh);
            4'd1, 4'd4, 4'd7: r.b = (w.b - w.c - w.a) ^ (w.a << sh);
            default:          r.c = (w.c - w.a - w.b) ^ (w.b >> sh);
        endcase
        return r;
    endfunction

    function automatic t_words add_words(t_words x, t_words y);
        t_words r;
        r.a = x.a + y.a;
        r.b = x.b + y.b;
        r.c = x.c + y.c;
        return r;
    endfunction

endpackage

FILE: sv/bslh_if.sv
// Handshake interfaces for the key byte input, the hash output and the seed write channel.
interface bslh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
    modport source (output valid, output data_byte, output byte_valid, output last, input ready);
    modport sink (input valid, input data_byte, input byte_valid, input last, output ready);
endinterface

interface bslh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest;
    modport source (output valid, output digest, input ready);
    modport sink (input valid, input digest, output ready);
endinterface

interface bslh_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] seed;
    modport source (output valid, output seed, input ready);
    modport sink (input valid, input seed, output ready);
endinterface

FILE: sv/bslh_front.sv
// Front end: takes key bytes, gathers 12-byte groups and builds group and final jobs.
module bslh_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    bslh_in_if.sink         i_in,
    bslh_cfg_if.sink        i_cfg,
    input  logic            i_q_ready,
    output logic            o_push,
    output bslh_pkg::t_job  o_job
);
    import bslh_pkg::*;

    logic [7:0]  r_bytes [GROUP_LEN];
    logic [7:0]  n_bytes [GROUP_LEN];
    logic [7:0]  tail    [GROUP_LEN];
    logic [3:0]  r_fill;
    logic [3:0]  fill_after;
    logic [3:0]  tail_fill;
    logic [31:0] r_count;
    logic [31:0] count_after;
    logic [31:0] r_seed;
    logic [31:0] r_key_seed;
    logic [31:0] seed_now;
    logic        r_key_open;
    logic        r_first_pending;
    logic        accept;
    logic        grp_done;

    assign i_in.ready  = i_q_ready;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_in.valid && i_in.ready;

    assign seed_now    = r_key_open ? r_key_seed : r_seed;
    assign fill_after  = r_fill + 4'(i_in.byte_valid);
    assign count_after = r_count + 32'(i_in.byte_valid);
    assign grp_done    = i_in.byte_valid && (r_fill == 4'(GROUP_LEN - 1));
    assign tail_fill   = grp_done ? 4'd0 : fill_after;

    always_comb begin
        for (int i = 0; i < GROUP_LEN; i++) begin
            n_bytes[i] = (i_in.byte_valid && r_fill == 4'(i)) ? i_in.data_byte : r_bytes[i];
            tail[i]    = (4'(i) < tail_fill) ? n_bytes[i] : 8'h00;
        end
    end

    always_comb begin
        o_job.first     = r_first_pending;
        o_job.seed      = seed_now;
        o_job.has_group = grp_done;
        o_job.grp.a     = {n_bytes[3], n_bytes[2], n_bytes[1], n_bytes[0]};
        o_job.grp.b     = {n_bytes[7], n_bytes[6], n_bytes[5], n_bytes[4]};
        o_job.grp.c     = {n_bytes[11], n_bytes[10], n_bytes[9], n_bytes[8]};
        o_job.has_final = i_in.last;
        o_job.fin.a     = {tail[3], tail[2], tail[1], tail[0]};
        o_job.fin.b     = {tail[7], tail[6], tail[5], tail[4]};
        o_job.fin.c     = count_after + {tail[10], tail[9], tail[8], 8'h00};
    end

    assign o_push = accept && (grp_done || i_in.last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed          <= '0;
            r_key_open      <= 1'b0;
            r_first_pending <= 1'b1;
            r_fill          <= '0;
            r_count         <= '0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_seed <= i_cfg.seed;
            end
            if (accept) begin
                if (i_in.last) begin
                    r_key_open      <= 1'b0;
                    r_first_pending <= 1'b1;
                    r_fill          <= '0;
                    r_count         <= '0;
                end else begin
                    r_key_open      <= 1'b1;
                    r_first_pending <= r_first_pending && !o_push;
                    r_fill          <= grp_done ? 4'd0 : fill_after;
                    r_count         <= count_after;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key_seed <= seed_now;
            r_bytes    <= n_bytes;
        end
    end

endmodule

FILE: sv/bslh_queue.sv
// Short first-in first-out queue of jobs between the front end and the mixing back end.
module bslh_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bslh_pkg::t_job  i_job,
    output logic            o_ready,
    output logic            o_valid,
    output bslh_pkg::t_job  o_job,
    input  logic            i_pop
);
    import bslh_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

FILE: sv/bslh_back.sv
// Back end: adds job words into the three mixing words, runs the mix and delivers the hash.
module bslh_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  bslh_pkg::t_job  i_job,
    output logic            o_q_pop,
    bslh_out_if.source      o_out
);
    import bslh_pkg::*;

    t_back_state r_state;
    t_back_state n_state;
    t_job        r_job;
    t_words      r_w;
    t_words      mixed;
    t_words      base;
    t_step       r_step;
    logic        r_final_phase;
    logic        r_out_valid;
    logic [31:0] r_hash;
    logic        last_step;
    logic        out_free;
    logic        emit;
    logic        advance;

    assign mixed     = mix_step(r_w, r_step);
    assign last_step = (r_step == t_step'(MIX_STEPS - 1));
    assign out_free  = !r_out_valid || o_out.ready;
    assign base      = i_job.first ? t_words'{a: GOLDEN, b: GOLDEN, c: i_job.seed} : r_w;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = ST_MIX;
                end
            end
            ST_MIX: begin
                if (last_step) begin
                    if (r_final_phase ? out_free : !r_job.has_final) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop = 1'b0;
        emit    = 1'b0;
        advance = 1'b0;
        unique case (r_state)
            ST_IDLE: o_q_pop = i_q_valid;
            ST_MIX: begin
                advance = !(last_step && r_final_phase && !out_free);
                emit    = last_step && r_final_phase && out_free;
            end
            default: o_q_pop = 1'b0;
        endcase
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.digest = r_hash;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job         <= i_job;
            r_w           <= add_words(base, i_job.has_group ? i_job.grp : i_job.fin);
            r_final_phase <= !i_job.has_group;
            r_step        <= '0;
        end else if (advance) begin
            if (last_step && !r_final_phase && r_job.has_final) begin
                r_w           <= add_words(mixed, r_job.fin);
                r_final_phase <= 1'b1;
                r_step        <= '0;
            end else begin
                r_w    <= mixed;
                r_step <= r_step + t_step'(1);
            end
        end
        if (emit) begin
            r_hash <= mixed.c;
        end
    end

endmodule

FILE: sv/byte_stream_lookup2_hash_core.sv
// Top level of the streaming lookup2 hash core.
// The core takes at most one key byte per request and returns one 32-bit hash per key,
// after the request that carries last. The front end accepts a byte every cycle while the
// queue has room; every twelfth byte and every key end become a job in a queue of
// QUEUE_DEPTH entries. The back end spends one add and nine mixing rounds on a full group
// and one or two such passes on a key end, so long keys stream at one byte per cycle,
// while a run of very short keys is limited by the mixing unit once the queue fills. The
// hash leaves through an output register, so the next key proceeds while a result waits
// to be taken. The seed is sampled on the first request of each key.
module byte_stream_lookup2_hash_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bslh_in_if.sink    i_in,
    bslh_cfg_if.sink   i_cfg,
    bslh_out_if.source o_out
);
    import bslh_pkg::*;

    t_job push_job;
    t_job head_job;
    logic push;
    logic q_ready;
    logic q_valid;
    logic q_pop;

    bslh_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_cfg     (i_cfg),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_job     (push_job)
    );

    bslh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_job   (head_job),
        .i_pop   (q_pop)
    );

    bslh_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_job     (head_job),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

FILE: tb/byte_stream_lookup2_hash_core_test.sv
// Self-checking testbench that streams random and corner-case keys through the lookup2 hash core.
module byte_stream_lookup2_hash_core_test;

    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASE_ITEMS  = 65;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last;
    } t_key_request;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_SPARSE,
        STALL_BURSTY
    } t_stall_mode;

    logic i_clk;
    logic i_rst_n = 1'b0;

    bslh_in_if  key_if ();
    bslh_out_if hash_if ();
    bslh_cfg_if seed_if ();

    byte_stream_lookup2_hash_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (key_if),
        .i_cfg   (seed_if),
        .o_out   (hash_if)
    );

    // Software copy of the hashing state.
    bit [31:0]   seed_value;
    bit [31:0]   word_a;
    bit [31:0]   word_b;
    bit [31:0]   word_c;
    bit [7:0]    group_bytes [12];
    int unsigned group_fill;
    bit [31:0]   key_length;
    bit          key_open;

    t_key_request pending_requests [$];
    bit [31:0]    expected_hashes [$];

    int requests_queued;
    int requests_accepted;
    int keys_queued;
    int hashes_checked;
    int seed_writes;
    int error_count;
    int cycle_count;

    int          burst_left;
    int          idle_gap;
    t_stall_mode stall_mode;
    int          stall_left;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void lookup2_mix(inout bit [31:0] a, inout bit [31:0] b,
                                        inout bit [31:0] c);
        a = a - b - c; a = a ^ (c >> 13);
        b = b - c - a; b = b ^ (a << 8);
        c = c - a - b; c = c ^ (b >> 13);
        a = a - b - c; a = a ^ (c >> 12);
        b = b - c - a; b = b ^ (a << 16);
        c = c - a - b; c = c ^ (b >> 5);
        a = a - b - c; a = a ^ (c >> 3);
        b = b - c - a; b = b ^ (a << 10);
        c = c - a - b; c = c ^ (b >> 15);
    endfunction

    function automatic void start_key();
        word_a     = bslh_pkg::GOLDEN;
        word_b     = bslh_pkg::GOLDEN;
        word_c     = seed_value;
        group_fill = 0;
        key_length = 0;
    endfunction

    // Advances the hashing state by one accepted request and queues the hash at a key end.
    function automatic void absorb_request(t_key_request req);
        bit [31:0] lane [3];
        bit [31:0] v;
        if (!key_open) begin
            start_key();
            key_open = 1'b1;
        end
        if (req.byte_valid) begin
            group_bytes[group_fill] = req.data_byte;
            group_fill++;
            key_length++;
            if (group_fill == 12) begin
                lane = '{32'd0, 32'd0, 32'd0};
                for (int i = 0; i < 12; i++)
                    lane[i / 4] += {24'd0, group_bytes[i]} << (8 * (i % 4));
                word_a += lane[0];
                word_b += lane[1];
                word_c += lane[2];
                lookup2_mix(word_a, word_b, word_c);
                group_fill = 0;
            end
        end
        if (req.last) begin
            word_c += key_length;
            for (int i = 0; i < group_fill; i++) begin
                v = {24'd0, group_bytes[i]};
                if (i < 4)
                    word_a += v << (8 * i);
                else if (i < 8)
                    word_b += v << (8 * (i - 4));
                else
                    word_c += v << (8 * (i - 7));
            end
            lookup2_mix(word_a, word_b, word_c);
            expected_hashes.push_back(word_c);
            start_key();
            key_open = 1'b0;
        end
    endfunction

    task automatic push_request(logic [7:0] data, logic byte_valid, logic last);
        t_key_request req;
        req.data_byte  = data;
        req.byte_valid = byte_valid;
        req.last       = last;
        pending_requests.push_back(req);
        requests_queued++;
    endtask

    // Queues a key of the given length, with idle requests scattered through it.
    task automatic queue_key(int len, bit close, inout int counted);
        bit end_marker;
        end_marker = (len == 0) || ($urandom_range(0, 4) == 0);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0)
                push_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            push_request(8'($urandom_range(0, 255)), 1'b1,
                         close && !end_marker && i == len - 1);
            counted++;
        end
        if (close && end_marker) begin
            push_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            counted++;
        end
        if (close)
            keys_queued++;
    endtask

    task automatic queue_random_phase(int target, bit leave_open);
        int counted;
        int pick;
        int len;
        counted = 0;
        while (counted < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                len = 0;
            else if (pick < 55)
                len = $urandom_range(1, 12);
            else if (pick < 85)
                len = $urandom_range(13, 36);
            else
                len = $urandom_range(37, 90);
            queue_key(len, 1'b1, counted);
        end
        if (leave_open)
            queue_key($urandom_range(1, 20), 1'b0, counted);
    endtask

    task automatic wait_until_idle();
        while (requests_accepted != requests_queued || expected_hashes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_seed(bit [31:0] value);
        @(posedge i_clk);
        seed_if.valid <= 1'b1;
        seed_if.seed  <= value;
        do @(posedge i_clk); while (!seed_if.ready);
        seed_if.valid <= 1'b0;
        seed_value = value;
        seed_writes++;
    endtask

    always @(posedge i_clk) begin : request_driver
        t_key_request req;
        if (i_rst_n) begin
            if (key_if.valid && key_if.ready) begin
                req.data_byte  = key_if.data_byte;
                req.byte_valid = key_if.byte_valid;
                req.last       = key_if.last;
                absorb_request(req);
                requests_accepted++;
            end
            if (!key_if.valid || key_if.ready) begin
                if (idle_gap > 0) begin
                    idle_gap--;
                    key_if.valid <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    req = pending_requests.pop_front();
                    key_if.valid      <= 1'b1;
                    key_if.data_byte  <= req.data_byte;
                    key_if.byte_valid <= req.byte_valid;
                    key_if.last       <= req.last;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        idle_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    key_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : hash_receiver
        bit [31:0] want;
        if (i_rst_n) begin
            if (hash_if.valid && hash_if.ready) begin
                if (expected_hashes.size() == 0) begin
                    $error("digest: none expected, got %08h", hash_if.digest);
                    error_count++;
                end else begin
                    want = expected_hashes.pop_front();
                    hashes_checked++;
                    if (hash_if.digest !== want) begin
                        $error("digest mismatch: expected %08h, got %08h",
                               want, hash_if.digest);
                        error_count++;
                    end
                end
            end
            if (stall_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                stall_left = $urandom_range(20, 200);
            end else begin
                stall_left--;
            end
            case (stall_mode)
                STALL_NONE:   hash_if.ready <= 1'b1;
                STALL_COIN:   hash_if.ready <= 1'($urandom_range(0, 1));
                STALL_SPARSE: hash_if.ready <= ($urandom_range(0, 3) == 0);
                default:      hash_if.ready <= (stall_left % 16) < 6;
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out with %0d hashes outstanding.", expected_hashes.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        bit [31:0] seeds [5];
        key_if.valid      = 1'b0;
        key_if.data_byte  = 8'd0;
        key_if.byte_valid = 1'b0;
        key_if.last       = 1'b0;
        hash_if.ready     = 1'b0;
        seed_if.valid     = 1'b0;
        seed_if.seed      = 32'd0;
        seed_value        = 32'd0;
        key_open          = 1'b0;
        start_key();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty key, idle request, single extreme bytes, one exact group, and an end marker.
        push_request(8'h00, 1'b0, 1'b1);
        push_request(8'hA5, 1'b0, 1'b0);
        push_request(8'h00, 1'b1, 1'b1);
        push_request(8'hFF, 1'b1, 1'b1);
        for (int i = 0; i < 12; i++)
            push_request((i % 2) ? 8'h00 : 8'hFF, 1'b1, i == 11);
        push_request(8'h80, 1'b1, 1'b0);
        push_request(8'h7F, 1'b0, 1'b0);
        push_request(8'hFF, 1'b0, 1'b1);
        keys_queued += 5;

        // Odd phases end with a key left open, so that a seed write lands mid-key.
        seeds = '{32'hFFFF_FFFF, $urandom, 32'h0000_0000, 32'h8000_0000, $urandom};
        for (int p = 0; p < 5; p++) begin
            wait_until_idle();
            write_seed(seeds[p]);
            queue_random_phase(PHASE_ITEMS, p == 1 || p == 3);
        end
        wait_until_idle();

        $display("Covered %0d requests over %0d keys under %0d seed values.",
                 requests_accepted, keys_queued, seed_writes + 1);
        $display("Checked %0d hashes with %0d mismatches.", hashes_checked, error_count);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
